// ===== hw/rtl/hilbert_4d_encode_decode_defines.svh =====
// Assertion macros for the Hilbert curve converter.
// Used by h4d_egress and hilbert_4d_encode_decode; depends on nothing.
`ifndef HILBERT_4D_ENCODE_DECODE_DEFINES_SVH
`define HILBERT_4D_ENCODE_DECODE_DEFINES_SVH
`ifndef SYNTHESIS
`define H4D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("h4d assertion failed");
`define H4D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("h4d assertion failed");
`define H4D_ASSERT_AFTER(lbl, clk, rst_n, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("h4d assertion failed");
`else
`define H4D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define H4D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define H4D_ASSERT_AFTER(lbl, clk, rst_n, ante, dly, cons)
`endif
`endif

// ===== hw/rtl/h4d_pkg.sv =====
// Shared constants and types for the 4-axis Hilbert curve converter.
// Depends on nothing; used by every module of the block.
package h4d_pkg;

	localparam int DEF_NUM_AXES      = 4;
	localparam int DEF_BITS_PER_AXIS = 32;
	localparam int MAX_AXES          = 4;
	localparam int COORD_W           = 32;
	localparam int INDEX_W           = 64;
	localparam int FULL_INDEX_W      = 2 * INDEX_W;

	// command codes
	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// control that travels with each request down the chain
	typedef struct packed {
		logic valid;
		logic cmd;
	} ctl_t;

endpackage

// ===== hw/rtl/h4d_ingress.sv =====
// Front stage: loads coordinates or splits the index into transposed form,
// and undoes the Gray step for decode. Depends on h4d_pkg.
module h4d_ingress #(
	parameter int NUM_AXES      = 4,
	parameter int BITS_PER_AXIS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           command,
	input  logic [h4d_pkg::COORD_W-1:0]    coord_0,
	input  logic [h4d_pkg::COORD_W-1:0]    coord_1,
	input  logic [h4d_pkg::COORD_W-1:0]    coord_2,
	input  logic [h4d_pkg::COORD_W-1:0]    coord_3,
	input  logic [h4d_pkg::INDEX_W-1:0]    index_upper,
	input  logic [h4d_pkg::INDEX_W-1:0]    index_lower,
	output h4d_pkg::ctl_t                  ctl_out,
	output logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] x_out
);
	import h4d_pkg::*;

	logic [MAX_AXES-1:0][COORD_W-1:0]        crd;
	logic [FULL_INDEX_W-1:0]                 idx;
	logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0]  enc_x;
	logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0]  dec_x;
	logic [BITS_PER_AXIS-1:0]                top_half;
	ctl_t                                    ctl_s1;
	logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0]  x_s1;

	assign crd = {coord_3, coord_2, coord_1, coord_0};
	assign idx = {index_upper, index_lower};

	// pick the low bits of each used coordinate
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			enc_x[a] = crd[a][BITS_PER_AXIS-1:0];
		end
	end

	// deinterleave the index, then undo the Gray step
	always_comb begin
		logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] raw;
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int j = 0; j < BITS_PER_AXIS; j++) begin
				raw[a][j] = idx[j * NUM_AXES + NUM_AXES - 1 - a];
			end
		end
		top_half = raw[NUM_AXES-1] >> 1;
		dec_x = raw;
		for (int i = NUM_AXES - 1; i > 0; i--) begin
			dec_x[i] = raw[i] ^ raw[i-1];
		end
		dec_x[0] = raw[0] ^ top_half;
	end

	// hold control under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.cmd   <= command;
		end
	end

	// capture the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= (command == CMD_DECODE) ? dec_x : enc_x;
		end
	end

	assign ctl_out = ctl_s1;
	assign x_out   = x_s1;

endmodule

// ===== hw/rtl/h4d_level_cell.sv =====
// One level of the Hilbert untangling chain: all axis swaps for one bit level.
// Encode runs levels from the top down, decode from the bottom up. Depends on h4d_pkg.
module h4d_level_cell #(
	parameter int NUM_AXES      = 4,
	parameter int BITS_PER_AXIS = 32,
	parameter int STAGE         = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  h4d_pkg::ctl_t                          ctl_in,
	input  logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] x_in,
	output h4d_pkg::ctl_t                          ctl_out,
	output logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] x_out
);
	import h4d_pkg::*;

	localparam int ENC_BIT = BITS_PER_AXIS - 1 - STAGE;
	localparam int DEC_BIT = STAGE + 1;
	localparam logic [BITS_PER_AXIS-1:0] ENC_MASK =
		{BITS_PER_AXIS{1'b1}} >> (BITS_PER_AXIS - ENC_BIT);
	localparam logic [BITS_PER_AXIS-1:0] DEC_MASK =
		{BITS_PER_AXIS{1'b1}} >> (BITS_PER_AXIS - DEC_BIT);

	logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] nx;
	ctl_t                                   ctl_q;
	logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] x_q;

	// swap or invert low bits against axis 0, one axis after another
	always_comb begin
		logic [BITS_PER_AXIS-1:0] t;
		nx = x_in;
		t  = '0;
		if (ctl_in.cmd == CMD_ENCODE) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (nx[a][ENC_BIT]) begin
					nx[0] = nx[0] ^ ENC_MASK;
				end else begin
					t     = (nx[0] ^ nx[a]) & ENC_MASK;
					nx[0] = nx[0] ^ t;
					nx[a] = nx[a] ^ t;
				end
			end
		end else begin
			for (int a = NUM_AXES - 1; a >= 0; a--) begin
				if (nx[a][DEC_BIT]) begin
					nx[0] = nx[0] ^ DEC_MASK;
				end else begin
					t     = (nx[0] ^ nx[a]) & DEC_MASK;
					nx[0] = nx[0] ^ t;
					nx[a] = nx[a] ^ t;
				end
			end
		end
	end

	// advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	// advance data
	always_ff @(posedge clk) begin
		if (ctl_in.valid) begin
			x_q <= nx;
		end
	end

	assign ctl_out = ctl_q;
	assign x_out   = x_q;

endmodule

// ===== hw/rtl/h4d_egress.sv =====
// Back stage: Gray step and interleave for encode, result registers for both.
// Depends on h4d_pkg and the defines header.
`include "hilbert_4d_encode_decode_defines.svh"
module h4d_egress #(
	parameter int NUM_AXES      = 4,
	parameter int BITS_PER_AXIS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  h4d_pkg::ctl_t                          ctl_in,
	input  logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] x_in,
	output logic                                   done,
	output logic [h4d_pkg::INDEX_W-1:0]            out_upper,
	output logic [h4d_pkg::INDEX_W-1:0]            out_lower,
	output logic [h4d_pkg::COORD_W-1:0]            axis_0,
	output logic [h4d_pkg::COORD_W-1:0]            axis_1,
	output logic [h4d_pkg::COORD_W-1:0]            axis_2,
	output logic [h4d_pkg::COORD_W-1:0]            axis_3
);
	import h4d_pkg::*;

	logic [FULL_INDEX_W-1:0]          enc_idx;
	logic                             done_q;
	logic [INDEX_W-1:0]               upper_q;
	logic [INDEX_W-1:0]               lower_q;
	logic [MAX_AXES-1:0][COORD_W-1:0] axis_q;

	// Gray step across axes, fold in the top-down parity mask, interleave
	always_comb begin
		logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] g;
		logic [BITS_PER_AXIS-1:0]               t;
		g = x_in;
		for (int i = 1; i < NUM_AXES; i++) begin
			g[i] = g[i] ^ g[i-1];
		end
		for (int k = 0; k < BITS_PER_AXIS; k++) begin
			t[k] = ^(g[NUM_AXES-1] >> (k + 1));
		end
		for (int i = 0; i < NUM_AXES; i++) begin
			g[i] = g[i] ^ t;
		end
		enc_idx = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int j = 0; j < BITS_PER_AXIS; j++) begin
				enc_idx[j * NUM_AXES + NUM_AXES - 1 - a] = g[a][j];
			end
		end
	end

	// drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_in.valid;
		end
	end

	// capture the result fields
	always_ff @(posedge clk) begin
		if (ctl_in.valid) begin
			if (ctl_in.cmd == CMD_ENCODE) begin
				upper_q <= enc_idx[FULL_INDEX_W-1:INDEX_W];
				lower_q <= enc_idx[INDEX_W-1:0];
				axis_q  <= '0;
			end else begin
				upper_q <= '0;
				lower_q <= '0;
				for (int a = 0; a < MAX_AXES; a++) begin
					if (a < NUM_AXES) begin
						axis_q[a] <= COORD_W'(x_in[a]);
					end else begin
						axis_q[a] <= '0;
					end
				end
			end
		end
	end

	assign done      = done_q;
	assign out_upper = upper_q;
	assign out_lower = lower_q;
	assign axis_0    = axis_q[0];
	assign axis_1    = axis_q[1];
	assign axis_2    = axis_q[2];
	assign axis_3    = axis_q[3];

	`H4D_ASSERT_NEXT(a_dec_index_zero, clk, arst_n, ctl_in.valid && ctl_in.cmd == CMD_DECODE, out_upper == '0 && out_lower == '0)
	`H4D_ASSERT_NEXT(a_enc_axes_zero, clk, arst_n, ctl_in.valid && ctl_in.cmd == CMD_ENCODE, axis_0 == '0 && axis_3 == '0)
	`H4D_ASSERT_NEXT(a_strobe_follows, clk, arst_n, !ctl_in.valid, !done)

endmodule

// ===== hw/rtl/hilbert_4d_encode_decode.sv =====
// Hilbert curve converter, NUM_AXES coordinates of BITS_PER_AXIS bits to one
// index and back. A request is taken whenever start is high; busy never rises,
// so one request can enter every cycle. Each result appears on the result ports
// for one cycle with done high, in request order; the receiver must take it then.
// Between a loading stage and a result stage lies a chain of BITS_PER_AXIS - 1
// level cells, one per bit level. Depends on h4d_pkg, h4d_ingress,
// h4d_level_cell, h4d_egress and the defines header.
`include "hilbert_4d_encode_decode_defines.svh"
module hilbert_4d_encode_decode #(
	parameter int NUM_AXES      = h4d_pkg::DEF_NUM_AXES,
	parameter int BITS_PER_AXIS = h4d_pkg::DEF_BITS_PER_AXIS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic [h4d_pkg::COORD_W-1:0] coord_0,
	input  logic [h4d_pkg::COORD_W-1:0] coord_1,
	input  logic [h4d_pkg::COORD_W-1:0] coord_2,
	input  logic [h4d_pkg::COORD_W-1:0] coord_3,
	input  logic [h4d_pkg::INDEX_W-1:0] index_upper,
	input  logic [h4d_pkg::INDEX_W-1:0] index_lower,
	output logic                        done,
	output logic [h4d_pkg::INDEX_W-1:0] out_upper,
	output logic [h4d_pkg::INDEX_W-1:0] out_lower,
	output logic [h4d_pkg::COORD_W-1:0] axis_0,
	output logic [h4d_pkg::COORD_W-1:0] axis_1,
	output logic [h4d_pkg::COORD_W-1:0] axis_2,
	output logic [h4d_pkg::COORD_W-1:0] axis_3
);
	import h4d_pkg::*;

	localparam int LATENCY = BITS_PER_AXIS + 1;

	logic                                   accept;
	ctl_t                                   ctl_c [BITS_PER_AXIS];
	logic [NUM_AXES-1:0][BITS_PER_AXIS-1:0] x_c   [BITS_PER_AXIS];

	// the chain takes a request every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	h4d_ingress #(
		.NUM_AXES      (NUM_AXES),
		.BITS_PER_AXIS (BITS_PER_AXIS)
	) u_ingress (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.coord_0     (coord_0),
		.coord_1     (coord_1),
		.coord_2     (coord_2),
		.coord_3     (coord_3),
		.index_upper (index_upper),
		.index_lower (index_lower),
		.ctl_out     (ctl_c[0]),
		.x_out       (x_c[0])
	);

	// one cell per bit level
	for (genvar k = 0; k < BITS_PER_AXIS - 1; k++) begin : g_cell
		h4d_level_cell #(
			.NUM_AXES      (NUM_AXES),
			.BITS_PER_AXIS (BITS_PER_AXIS),
			.STAGE         (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[k]),
			.x_in    (x_c[k]),
			.ctl_out (ctl_c[k+1]),
			.x_out   (x_c[k+1])
		);
	end

	h4d_egress #(
		.NUM_AXES      (NUM_AXES),
		.BITS_PER_AXIS (BITS_PER_AXIS)
	) u_egress (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_c[BITS_PER_AXIS-1]),
		.x_in      (x_c[BITS_PER_AXIS-1]),
		.done      (done),
		.out_upper (out_upper),
		.out_lower (out_lower),
		.axis_0    (axis_0),
		.axis_1    (axis_1),
		.axis_2    (axis_2),
		.axis_3    (axis_3)
	);

	`H4D_ASSERT_AFTER(a_result_latency, clk, arst_n, accept, LATENCY, done)
	`H4D_ASSERT_IMPL(a_never_busy, clk, arst_n, start, !busy)
	`H4D_ASSERT_NEXT(a_head_follows_accept, clk, arst_n, accept, ctl_c[0].valid)

endmodule

// ===== bench/tb_hilbert_4d_encode_decode.sv =====
// Self-checking bench for the 4-axis Hilbert curve converter (encode and decode).
// Depends on h4d_pkg and hilbert_4d_encode_decode; carries its own bit-exact
// curve model and compares every strobed result against it in request order.
`timescale 1ns / 100ps
module tb_hilbert_4d_encode_decode;
	import h4d_pkg::*;

	localparam int AXES    = DEF_NUM_AXES;
	localparam int LEVELS  = DEF_BITS_PER_AXIS;
	localparam int LATENCY = LEVELS + 1;

	typedef logic [MAX_AXES-1:0][COORD_W-1:0] axes_t;

	typedef struct packed {
		logic                    cmd;
		axes_t                   coords;
		logic [FULL_INDEX_W-1:0] index;
	} point_request_t;

	typedef struct packed {
		logic [FULL_INDEX_W-1:0] index;
		axes_t                   axes;
	} point_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                command;
	logic [COORD_W-1:0]  coord_0;
	logic [COORD_W-1:0]  coord_1;
	logic [COORD_W-1:0]  coord_2;
	logic [COORD_W-1:0]  coord_3;
	logic [INDEX_W-1:0]  index_upper;
	logic [INDEX_W-1:0]  index_lower;
	logic                done;
	logic [INDEX_W-1:0]  out_upper;
	logic [INDEX_W-1:0]  out_lower;
	logic [COORD_W-1:0]  axis_0;
	logic [COORD_W-1:0]  axis_1;
	logic [COORD_W-1:0]  axis_2;
	logic [COORD_W-1:0]  axis_3;

	point_result_t           expected_results[$];
	int                      mismatches;
	int                      sender_idle_pct;
	logic [FULL_INDEX_W-1:0] last_encoded_index;

	hilbert_4d_encode_decode i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.coord_0     (coord_0),
		.coord_1     (coord_1),
		.coord_2     (coord_2),
		.coord_3     (coord_3),
		.index_upper (index_upper),
		.index_lower (index_lower),
		.done        (done),
		.out_upper   (out_upper),
		.out_lower   (out_lower),
		.axis_0      (axis_0),
		.axis_1      (axis_1),
		.axis_2      (axis_2),
		.axis_3      (axis_3)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Untangle one bit level q against axis a: invert or swap the lower bits
	function automatic axes_t untangle(axes_t x, int a, logic [COORD_W-1:0] q);
		logic [COORD_W-1:0] low_mask;
		logic [COORD_W-1:0] t;
		low_mask = q - 1;
		if ((x[a] & q) != 0) begin
			x[0] = x[0] ^ low_mask;
		end else begin
			t    = (x[0] ^ x[a]) & low_mask;
			x[0] = x[0] ^ t;
			x[a] = x[a] ^ t;
		end
		return x;
	endfunction

	// Coordinates to transposed form, then interleave levels, axis 0 on top
	function automatic logic [FULL_INDEX_W-1:0] hilbert_encode(axes_t x);
		logic [COORD_W-1:0]      t;
		logic [FULL_INDEX_W-1:0] idx;
		int                      b;
		int                      i;
		int                      j;
		for (b = LEVELS - 1; b >= 1; b--)
			for (i = 0; i < AXES; i++)
				x = untangle(x, i, 1 << b);
		for (i = 1; i < AXES; i++)
			x[i] = x[i] ^ x[i-1];
		t = '0;
		for (b = LEVELS - 1; b >= 1; b--)
			if (x[AXES-1][b])
				t = t ^ ((1 << b) - 1);
		idx = '0;
		for (i = 0; i < AXES; i++) begin
			x[i] = x[i] ^ t;
			for (j = 0; j < LEVELS; j++)
				idx[j*AXES + AXES - 1 - i] = x[i][j];
		end
		return idx;
	endfunction

	// De-interleave into transposed form, then unwind back to coordinates
	function automatic axes_t hilbert_decode(logic [FULL_INDEX_W-1:0] idx);
		axes_t              x;
		logic [COORD_W-1:0] t;
		int                 b;
		int                 i;
		int                 j;
		x = '0;
		for (i = 0; i < AXES; i++)
			for (j = 0; j < LEVELS; j++)
				x[i][j] = idx[j*AXES + AXES - 1 - i];
		t = x[AXES-1] >> 1;
		for (i = AXES - 1; i > 0; i--)
			x[i] = x[i] ^ x[i-1];
		x[0] = x[0] ^ t;
		for (b = 1; b < LEVELS; b++)
			for (i = AXES - 1; i >= 0; i--)
				x = untangle(x, i, 1 << b);
		return x;
	endfunction

	function automatic point_result_t predict_point(point_request_t r);
		point_result_t res;
		res = '0;
		if (r.cmd == CMD_ENCODE)
			res.index = hilbert_encode(r.coords);
		else
			res.axes = hilbert_decode(r.index);
		return res;
	endfunction

	// Half full-range words, the rest zeros, ones, single bits, small values and their inverses
	function automatic logic [COORD_W-1:0] random_word();
		logic [COORD_W-1:0] w;
		case ($urandom_range(9, 0))
			5:       w = $urandom_range(15, 0);
			6:       w = ~COORD_W'($urandom_range(15, 0));
			7:       w = COORD_W'(1) << $urandom_range(COORD_W - 1, 0);
			8:       w = '0;
			9:       w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic point_request_t random_request();
		point_request_t r;
		int             i;
		r.cmd = $urandom_range(1, 0) ? CMD_DECODE : CMD_ENCODE;
		for (i = 0; i < MAX_AXES; i++)
			r.coords[i] = random_word();
		// Round-trip some decodes through the last encoded index
		if (r.cmd == CMD_DECODE && $urandom_range(3, 0) == 0)
			r.index = last_encoded_index;
		else
			r.index = {random_word(), random_word(), random_word(), random_word()};
		return r;
	endfunction

	// Drive one request, hold it until taken, then record its expected result
	task automatic send_request(input point_request_t r);
		point_result_t res;
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		command     <= r.cmd;
		coord_0     <= r.coords[0];
		coord_1     <= r.coords[1];
		coord_2     <= r.coords[2];
		coord_3     <= r.coords[3];
		index_upper <= r.index[FULL_INDEX_W-1:INDEX_W];
		index_lower <= r.index[INDEX_W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		res = predict_point(r);
		if (r.cmd == CMD_ENCODE)
			last_encoded_index = res.index;
		expected_results.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [INDEX_W-1:0] want,
			input logic [INDEX_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare each strobed result with the oldest pending request
	always @(posedge clk) begin : check_results
		point_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none got index %h_%h axes %h %h %h %h",
					$time, out_upper, out_lower, axis_0, axis_1, axis_2, axis_3);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("out_upper", want.index[FULL_INDEX_W-1:INDEX_W], out_upper);
				check_field("out_lower", want.index[INDEX_W-1:0], out_lower);
				check_field("axis_0", INDEX_W'(want.axes[0]), INDEX_W'(axis_0));
				check_field("axis_1", INDEX_W'(want.axes[1]), INDEX_W'(axis_1));
				check_field("axis_2", INDEX_W'(want.axes[2]), INDEX_W'(axis_2));
				check_field("axis_3", INDEX_W'(want.axes[3]), INDEX_W'(axis_3));
			end
		end
	end

	// Encode corners: origin, full scale, one axis at a time, checkerboards
	task automatic test_encode_corners();
		point_request_t r;
		int             k;
		r = '0;
		r.cmd = CMD_ENCODE;
		send_request(r);
		r.coords = '1;
		send_request(r);
		for (k = 0; k < MAX_AXES; k++) begin
			r.coords    = '0;
			r.coords[k] = '1;
			send_request(r);
			r.coords[k] = 1;
			send_request(r);
		end
		r.coords = {4{32'hAAAA_AAAA}};
		send_request(r);
	endtask

	// Decode corners: zero, all ones, lowest and highest bit, half words, patterns
	task automatic test_decode_corners();
		point_request_t r;
		r = '0;
		r.cmd = CMD_DECODE;
		send_request(r);
		r.index = '1;
		send_request(r);
		r.index = 1;
		send_request(r);
		r.index = {1'b1, {(FULL_INDEX_W-1){1'b0}}};
		send_request(r);
		r.index = {{INDEX_W{1'b1}}, {INDEX_W{1'b0}}};
		send_request(r);
		r.index = {{INDEX_W{1'b0}}, {INDEX_W{1'b1}}};
		send_request(r);
		r.index = {8{16'h5A5A}};
		send_request(r);
		r.index = {8{16'h8001}};
		send_request(r);
	endtask

	// Random mix of encodes and decodes at one sender idle rate
	task automatic test_random_traffic(input int count, input int idle_pct);
		int n;
		sender_idle_pct = idle_pct;
		for (n = 0; n < count; n++)
			send_request(random_request());
	endtask

	initial begin
		mismatches         = 0;
		sender_idle_pct    = 0;
		last_encoded_index = '0;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		command     <= CMD_ENCODE;
		coord_0     <= '0;
		coord_1     <= '0;
		coord_2     <= '0;
		coord_3     <= '0;
		index_upper <= '0;
		index_lower <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_corners();
		test_decode_corners();
		test_random_traffic(400, 0);
		test_random_traffic(400, 54);
		test_random_traffic(350, 10);
		start <= 1'b0;

		// Drain, then watch for stray strobes
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("== FAIL ==");
		$finish;
	end

endmodule
